@@ rtl/sbob_pkg.sv @@
package sbob_pkg;

   localparam int ADDR_W = 14;
   localparam int DATA_W = 32;
   localparam int SHIFT_W = 5;
   localparam int COL_W = 5;
   localparam int ROW_W = 9;
   localparam int X_W = 10;
   localparam int Y_W = 9;
   localparam int QUEUE_DEPTH = 2;

   // Words in one frame buffer pixel line.
   localparam logic [ADDR_W-1:0] LINE_WORDS = 14'd20;

   localparam logic [X_W-1:0] RESET_DEST_X = 10'd0;
   localparam logic [Y_W-1:0] RESET_DEST_Y = 9'd0;
   localparam logic [X_W-1:0] RESET_SPRITE_WIDTH = 10'd32;
   localparam logic [Y_W-1:0] RESET_SPRITE_HEIGHT = 9'd32;

   typedef enum logic [1:0] {
      REG_DEST_X        = 2'd0,
      REG_DEST_Y        = 2'd1,
      REG_SPRITE_WIDTH  = 2'd2,
      REG_SPRITE_HEIGHT = 2'd3
   } sbob_reg_type;

   typedef struct packed {
      logic [X_W-1:0] dest_x;
      logic [Y_W-1:0] dest_y;
      logic [X_W-1:0] sprite_width;
      logic [Y_W-1:0] sprite_height;
   } sbob_cfg_type;

   // One classified sprite word waiting for the write stage.
   typedef struct packed {
      logic [ADDR_W-1:0]  word_address;
      logic [DATA_W-1:0]  bitmap_word;
      logic [SHIFT_W-1:0] shift;
      logic               blit_done;
   } sbob_entry_type;

endpackage

@@ rtl/sbob_front.sv @@
module sbob_front import sbob_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  sbob_cfg_type   cfg,
   input  logic           restart,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [DATA_W-1:0] in_word,
   output logic           push,
   output sbob_entry_type push_entry,
   input  logic           queue_full
);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic [X_W:0]     width_round;
   logic [COL_W:0]   row_words;
   logic [ROW_W-1:0] rows;
   logic             row_end;
   logic             last_row;
   logic             done;
   logic [Y_W:0]     line;
   logic [ADDR_W-1:0] line_base;

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   always_comb begin
      width_round = {1'b0, cfg.sprite_width} + 11'd31;
      row_words = width_round[X_W:SHIFT_W];
      if (row_words == '0) begin
         row_words = 6'd1;
      end
      rows = (cfg.sprite_height == '0) ? 9'd1 : cfg.sprite_height;

      row_end  = ({1'b0, col_ff} + 6'd1) >= row_words;
      last_row = ({1'b0, row_ff} + 10'd1) >= {1'b0, rows};
      done     = row_end && last_row;

      // Line number stays within ten bits; the product wraps with the address.
      line      = {1'b0, cfg.dest_y} + {1'b0, row_ff};
      line_base = 14'({4'd0, line} * LINE_WORDS);

      push_entry.word_address = line_base + 14'(cfg.dest_x[X_W-1:SHIFT_W])
                                + 14'(col_ff);
      push_entry.bitmap_word  = in_word;
      push_entry.shift        = cfg.dest_x[SHIFT_W-1:0];
      push_entry.blit_done    = done;

      row_in = row_ff;
      col_in = col_ff;
      if (push) begin
         if (row_end) begin
            col_in = '0;
            row_in = done ? '0 : row_ff + 9'd1;
         end else begin
            col_in = col_ff + 5'd1;
         end
      end
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

@@ rtl/sbob_queue.sv @@
module sbob_queue import sbob_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sbob_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output sbob_entry_type head_entry
);

   sbob_entry_type slot_ff [QUEUE_DEPTH];
   sbob_entry_type slot_in [QUEUE_DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_entry;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/sbob_back.sv @@
module sbob_back import sbob_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  sbob_entry_type    head_entry,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ADDR_W-1:0] out_address,
   output logic [DATA_W-1:0] out_data,
   output logic              out_item_last,
   output logic              out_blit_done
);

   logic              valid_ff, valid_in;
   logic              phase_ff, phase_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   logic              done_ff, done_in;
   logic              load;
   logic              aligned;
   logic [SHIFT_W-1:0] left_shift;

   assign out_valid     = valid_ff;
   assign out_address   = addr_ff;
   assign out_data      = data_ff;
   assign out_item_last = last_ff;
   assign out_blit_done = done_ff;

   always_comb begin
      load       = !valid_ff || out_ready;
      aligned    = (head_entry.shift == '0);
      // 32 - shift, which is in range whenever the word is split.
      left_shift = (~head_entry.shift) + 5'd1;

      valid_in = valid_ff;
      phase_in = phase_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      pop      = 1'b0;

      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (aligned) begin
               addr_in = head_entry.word_address;
               data_in = head_entry.bitmap_word;
               last_in = 1'b1;
               done_in = head_entry.blit_done;
               pop     = 1'b1;
            end else if (!phase_ff) begin
               addr_in  = head_entry.word_address;
               data_in  = head_entry.bitmap_word >> head_entry.shift;
               last_in  = 1'b0;
               done_in  = 1'b0;
               phase_in = 1'b1;
            end else begin
               addr_in  = head_entry.word_address + 14'd1;
               data_in  = head_entry.bitmap_word << left_shift;
               last_in  = 1'b1;
               done_in  = head_entry.blit_done;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      data_ff <= data_in;
      last_ff <= last_in;
      done_ff <= done_in;
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/shifted_bitmap_or_blitter.sv @@
// An accepted item passes through the queue and then the result register before its first write
// is presented. One item per cycle is taken when dest_x is word aligned and rsp_tready does not
// stall; otherwise the single result port carries both split writes of each item.
// A two-entry queue separates the address front end from the write stage.
// Reset (synchronous, active high) empties the queue and result register, clears the row and
// column counters and loads dest_x 0, dest_y 0, sprite width 32 and sprite height 32.
module shifted_bitmap_or_blitter import sbob_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Sprite words in.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] bitmap_word
   // Frame buffer OR writes out.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [13:0] word_address, [45:14] or_data, [47:46] zero
   output logic        rsp_tlast,   // item_last
   output logic        rsp_tuser,   // [0] blit_done
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   sbob_cfg_type   cfg_ff, cfg_in;
   logic           cfg_write;
   sbob_reg_type   reg_sel;
   logic           push;
   sbob_entry_type push_entry;
   logic           queue_full;
   logic           pop;
   logic           head_valid;
   sbob_entry_type head_entry;
   logic [ADDR_W-1:0] out_address;
   logic [DATA_W-1:0] out_data;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = sbob_reg_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_sel)
            REG_DEST_X:        cfg_in.dest_x        = csr_pwdata[X_W-1:0];
            REG_DEST_Y:        cfg_in.dest_y        = csr_pwdata[Y_W-1:0];
            REG_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_pwdata[X_W-1:0];
            REG_SPRITE_HEIGHT: cfg_in.sprite_height = csr_pwdata[Y_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEST_X:        csr_prdata = 32'(cfg_ff.dest_x);
         REG_DEST_Y:        csr_prdata = 32'(cfg_ff.dest_y);
         REG_SPRITE_WIDTH:  csr_prdata = 32'(cfg_ff.sprite_width);
         REG_SPRITE_HEIGHT: csr_prdata = 32'(cfg_ff.sprite_height);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x        <= RESET_DEST_X;
         cfg_ff.dest_y        <= RESET_DEST_Y;
         cfg_ff.sprite_width  <= RESET_SPRITE_WIDTH;
         cfg_ff.sprite_height <= RESET_SPRITE_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Every register write starts a new sprite.
   sbob_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .restart    (cfg_write),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (req_tdata),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   sbob_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sbob_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_address   (out_address),
      .out_data      (out_data),
      .out_item_last (rsp_tlast),
      .out_blit_done (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, out_data, out_address};

   // An accepted item is waiting in the queue on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> head_valid)
      else $error("accepted item did not reach the queue");

   // The second half of a split word follows its first half at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("split write missing its second half");

   // The end of the sprite only comes on the last write of an item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("blit end flagged on a first half write");

   // A pop only happens while the write stage has an entry to take.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule
